[src/sbcc_pkg.sv]
// shared types, constants and helpers of the sixteen-bit processor core
`default_nettype none
package sbcc_pkg;

    localparam int MEM_ADDR_BITS = 16;
    localparam int MEM_WORDS     = 1 << MEM_ADDR_BITS;

    typedef enum logic [1:0] {
        CMD_EXEC  = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_READ  = 2'd2,
        CMD_NONE  = 2'd3
    } t_cmd;

    typedef enum logic [3:0] {
        OP_EXT = 4'h0, OP_SET = 4'h1, OP_ADD = 4'h2, OP_SUB = 4'h3,
        OP_MUL = 4'h4, OP_DIV = 4'h5, OP_MOD = 4'h6, OP_SHL = 4'h7,
        OP_SHR = 4'h8, OP_AND = 4'h9, OP_BOR = 4'ha, OP_XOR = 4'hb,
        OP_IFE = 4'hc, OP_IFN = 4'hd, OP_IFG = 4'he, OP_IFB = 4'hf
    } t_op;

    localparam logic [5:0] EXT_JSR     = 6'h01;
    localparam logic [5:0] CODE_POP    = 6'h18;
    localparam logic [5:0] CODE_PEEK   = 6'h19;
    localparam logic [5:0] CODE_PUSH   = 6'h1a;
    localparam logic [5:0] CODE_SP     = 6'h1b;
    localparam logic [5:0] CODE_PC     = 6'h1c;
    localparam logic [5:0] CODE_O      = 6'h1d;
    localparam logic [5:0] CODE_NWIND  = 6'h1e;
    localparam logic [5:0] CODE_NWLIT  = 6'h1f;

    typedef enum logic [2:0] {
        K_REG, K_MEM, K_SP, K_PC, K_OV, K_LIT
    } t_kind;

    typedef enum logic [3:0] {
        S_IDLE, S_HRD, S_FETCH, S_RES, S_NW, S_RD, S_RDW, S_EXEC,
        S_DIVW, S_WB, S_JSR, S_SKW, S_DONE
    } t_state;

    typedef struct packed {
        logic                     en;
        logic                     we;
        logic [MEM_ADDR_BITS-1:0] addr;
        logic [15:0]              wdata;
    } t_mem_req;

    typedef struct packed {
        logic [15:0] res;
        logic [15:0] ov;
        logic        ov_we;
        logic        cond;
    } t_alu_out;

    function automatic logic takes_word(input logic [5:0] c);
        return (c[5:3] == 3'b010) || (c == CODE_NWIND) || (c == CODE_NWLIT);
    endfunction

endpackage
`default_nettype wire

[src/sbcc_mem.sv]
// single-port word memory, registered read
`default_nettype none
module sbcc_mem (
    input  wire logic              i_clk,
    input  wire sbcc_pkg::t_mem_req i_req,
    output logic [15:0]            o_rdata
);
    logic [15:0] r_mem [sbcc_pkg::MEM_WORDS];
    logic [15:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_req.en) begin
            if (i_req.we) begin
                r_mem[i_req.addr] <= i_req.wdata;
            end else begin
                r_q <= r_mem[i_req.addr];
            end
        end
    end

    assign o_rdata = r_q;
endmodule
`default_nettype wire

[src/sbcc_div.sv]
// restoring divider, one quotient bit a cycle, 32 steps
`default_nettype none
module sbcc_div (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [15:0] i_dividend,
    input  wire logic [15:0] i_divisor,
    output logic             o_done,
    output logic [31:0]      o_quot,
    output logic [15:0]      o_rem
);
    logic        r_busy, r_done;
    logic [4:0]  r_cnt;
    logic [15:0] r_rem, r_dvs, r_mod;
    logic [31:0] r_dvd;
    logic [16:0] rs, diff;
    logic        ge;

    // dividend is a shifted up by 16: high quotient half is a/b, low half the overflow
    assign rs   = {r_rem, r_dvd[31]};
    assign diff = rs - {1'b0, r_dvs};
    assign ge   = rs >= {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= '0;
                r_dvs  <= i_divisor;
                r_dvd  <= {i_dividend, 16'h0000};
            end else if (r_busy) begin
                r_rem <= ge ? diff[15:0] : rs[15:0];
                r_dvd <= {r_dvd[30:0], ge};
                r_cnt <= r_cnt + 5'd1;
                // after the high half the partial remainder is a mod b
                if (r_cnt == 5'd15) begin
                    r_mod <= ge ? diff[15:0] : rs[15:0];
                end
                if (r_cnt == 5'd31) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_dvd;
    assign o_rem  = r_mod;
endmodule
`default_nettype wire

[src/sbcc_alu.sv]
// combinational arithmetic, logic, shift and compare unit
`default_nettype none
module sbcc_alu (
    input  wire sbcc_pkg::t_op     i_op,
    input  wire logic [15:0]       i_a,
    input  wire logic [15:0]       i_b,
    output sbcc_pkg::t_alu_out     o_out
);
    logic [16:0] sum, dif;
    logic [31:0] prod, shr_w;
    logic [47:0] shl_w;

    assign sum   = {1'b0, i_a} + {1'b0, i_b};
    assign dif   = {1'b0, i_a} - {1'b0, i_b};
    assign prod  = i_a * i_b;
    assign shl_w = {32'h0, i_a} << i_b;
    assign shr_w = {i_a, 16'h0000} >> i_b;

    always_comb begin
        o_out = '0;
        case (i_op)
            sbcc_pkg::OP_SET: o_out.res = i_b;
            sbcc_pkg::OP_ADD: begin
                o_out.res = sum[15:0]; o_out.ov = {15'h0, sum[16]}; o_out.ov_we = 1'b1;
            end
            sbcc_pkg::OP_SUB: begin
                o_out.res = dif[15:0]; o_out.ov = {16{dif[16]}}; o_out.ov_we = 1'b1;
            end
            sbcc_pkg::OP_MUL: begin
                o_out.res = prod[15:0]; o_out.ov = prod[31:16]; o_out.ov_we = 1'b1;
            end
            sbcc_pkg::OP_SHL: begin
                o_out.res = shl_w[15:0]; o_out.ov = shl_w[31:16]; o_out.ov_we = 1'b1;
            end
            sbcc_pkg::OP_SHR: begin
                o_out.res = shr_w[31:16]; o_out.ov = shr_w[15:0]; o_out.ov_we = 1'b1;
            end
            sbcc_pkg::OP_AND: o_out.res = i_a & i_b;
            sbcc_pkg::OP_BOR: o_out.res = i_a | i_b;
            sbcc_pkg::OP_XOR: o_out.res = i_a ^ i_b;
            sbcc_pkg::OP_IFE: o_out.cond = (i_a != i_b);
            sbcc_pkg::OP_IFN: o_out.cond = (i_a == i_b);
            sbcc_pkg::OP_IFG: o_out.cond = (i_a <= i_b);
            sbcc_pkg::OP_IFB: o_out.cond = ((i_a & i_b) == 16'h0000);
            default:          o_out = '0;
        endcase
    end
endmodule
`default_nettype wire

[src/sixteen_bit_cpu_core.sv]
// sixteen-bit processor core top level: sequencer, register state and host port
// one word at a time, accept to next accept varying by word: a host read waits on the
// registered memory read, an instruction's time depends on its operand forms, each memory
// access of an instruction takes its own turn on the single memory port, and div/mod by
// nonzero wait on the bit-serial divider
// reset: synchronous active-low; registers, pc, sp and overflow clear, memory keeps contents
// the result strobe lasts one cycle and cannot be held off by the receiver
`default_nettype none
module sixteen_bit_cpu_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  i_opcode,
    input  wire logic [15:0] i_address,
    input  wire logic [15:0] i_write_data,
    output logic             o_valid,
    output logic [15:0]      o_read_data,
    output logic [15:0]      o_program_counter,
    output logic [15:0]      o_overflow_word,
    output logic             o_unknown_op
);
    localparam int AW = sbcc_pkg::MEM_ADDR_BITS;

    // architectural state
    sbcc_pkg::t_state r_state, n_state;
    logic [15:0] r_gr [8];
    logic [15:0] r_pc, n_pc, r_sp, n_sp, r_ov, n_ov;

    // per-word working registers
    logic [15:0] r_ins, n_ins;
    logic        r_phb, n_phb;
    sbcc_pkg::t_kind r_kind, n_kind, r_kind_a, n_kind_a;
    logic [15:0] r_where, n_where, r_where_a, n_where_a;
    logic [15:0] r_val_a, n_val_a, r_val_b, n_val_b, r_res, n_res;
    logic [15:0] r_rdata, n_rdata;
    logic        r_unk, n_unk;

    // register file write and read
    logic        rf_we;
    logic [2:0]  rf_widx, rf_ridx;
    logic [15:0] rf_wdata, rf_q;

    sbcc_pkg::t_mem_req mem_req;
    logic [15:0]        mem_q;
    sbcc_pkg::t_alu_out alu;
    sbcc_pkg::t_op      op;
    logic               div_start, div_done;
    logic [31:0]        div_quot;
    logic [15:0]        div_rem;

    logic [5:0]  code;
    logic        basic;
    logic        fin;
    logic [15:0] fin_val;

    sbcc_mem u_mem (
        .i_clk   (i_clk),
        .i_req   (mem_req),
        .o_rdata (mem_q)
    );

    sbcc_alu u_alu (
        .i_op  (op),
        .i_a   (r_val_a),
        .i_b   (r_val_b),
        .o_out (alu)
    );

    sbcc_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_val_a),
        .i_divisor  (r_val_b),
        .o_done     (div_done),
        .o_quot     (div_quot),
        .o_rem      (div_rem)
    );

    assign op    = sbcc_pkg::t_op'(r_ins[3:0]);
    assign basic = (r_ins[3:0] != 4'h0);
    // operand a sits in bits 9:4 of a basic op, the lone operand of an extended op in 15:10
    assign code  = (r_phb || !basic) ? r_ins[15:10] : r_ins[9:4];

    // one register file read port, address picked by sequencer state
    assign rf_ridx = (r_state == sbcc_pkg::S_RD) ? r_where[2:0] : code[2:0];
    assign rf_q    = r_gr[rf_ridx];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sbcc_pkg::S_IDLE;
            r_pc    <= '0;
            r_sp    <= '0;
            r_ov    <= '0;
            r_phb   <= 1'b0;
            r_unk   <= 1'b0;
            r_rdata <= '0;
            for (int i = 0; i < 8; i++) begin
                r_gr[i] <= '0;
            end
        end else begin
            r_state <= n_state;
            r_pc    <= n_pc;
            r_sp    <= n_sp;
            r_ov    <= n_ov;
            r_phb   <= n_phb;
            r_unk   <= n_unk;
            r_rdata <= n_rdata;
            if (rf_we) begin
                r_gr[rf_widx] <= rf_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_ins     <= n_ins;
        r_kind    <= n_kind;
        r_kind_a  <= n_kind_a;
        r_where   <= n_where;
        r_where_a <= n_where_a;
        r_val_a   <= n_val_a;
        r_val_b   <= n_val_b;
        r_res     <= n_res;
    end

    always_comb begin
        n_state   = r_state;
        n_pc      = r_pc;
        n_sp      = r_sp;
        n_ov      = r_ov;
        n_phb     = r_phb;
        n_unk     = r_unk;
        n_rdata   = r_rdata;
        n_ins     = r_ins;
        n_kind    = r_kind;
        n_kind_a  = r_kind_a;
        n_where   = r_where;
        n_where_a = r_where_a;
        n_val_a   = r_val_a;
        n_val_b   = r_val_b;
        n_res     = r_res;
        rf_we     = 1'b0;
        rf_widx   = r_where_a[2:0];
        rf_wdata  = r_res;
        mem_req   = '0;
        div_start = 1'b0;
        fin       = 1'b0;
        fin_val   = mem_q;

        case (r_state)
            sbcc_pkg::S_IDLE: begin
                if (start) begin
                    n_rdata = '0;
                    n_unk   = 1'b0;
                    n_phb   = 1'b0;
                    case (sbcc_pkg::t_cmd'(i_opcode))
                        sbcc_pkg::CMD_EXEC: begin
                            mem_req.en   = 1'b1;
                            mem_req.addr = r_pc[AW-1:0];
                            n_pc         = r_pc + 16'd1;
                            n_state      = sbcc_pkg::S_FETCH;
                        end
                        sbcc_pkg::CMD_WRITE: begin
                            mem_req.en    = 1'b1;
                            mem_req.we    = 1'b1;
                            mem_req.addr  = i_address[AW-1:0];
                            mem_req.wdata = i_write_data;
                            n_state       = sbcc_pkg::S_DONE;
                        end
                        sbcc_pkg::CMD_READ: begin
                            mem_req.en   = 1'b1;
                            mem_req.addr = i_address[AW-1:0];
                            n_state      = sbcc_pkg::S_HRD;
                        end
                        default: n_state = sbcc_pkg::S_DONE;
                    endcase
                end
            end
            sbcc_pkg::S_HRD: begin
                n_rdata = mem_q;
                n_state = sbcc_pkg::S_DONE;
            end
            sbcc_pkg::S_FETCH: begin
                n_ins   = mem_q;
                n_state = sbcc_pkg::S_RES;
            end
            // decode the operand code: direct places here, next-word forms fetch first
            sbcc_pkg::S_RES: begin
                n_state = sbcc_pkg::S_RD;
                n_kind  = sbcc_pkg::K_MEM;
                if (code[5]) begin
                    n_kind  = sbcc_pkg::K_LIT;
                    n_where = {11'h0, code[4:0]};
                end else if (sbcc_pkg::takes_word(code)) begin
                    mem_req.en   = 1'b1;
                    mem_req.addr = r_pc[AW-1:0];
                    n_pc         = r_pc + 16'd1;
                    n_state      = sbcc_pkg::S_NW;
                end else if (code[5:3] == 3'b000) begin
                    n_kind  = sbcc_pkg::K_REG;
                    n_where = {13'h0, code[2:0]};
                end else if (code[5:3] == 3'b001) begin
                    n_where = rf_q;
                end else if (code == sbcc_pkg::CODE_POP) begin
                    n_where = r_sp;
                    n_sp    = r_sp + 16'd1;
                end else if (code == sbcc_pkg::CODE_PEEK) begin
                    n_where = r_sp;
                end else if (code == sbcc_pkg::CODE_PUSH) begin
                    n_where = r_sp - 16'd1;
                    n_sp    = r_sp - 16'd1;
                end else if (code == sbcc_pkg::CODE_SP) begin
                    n_kind = sbcc_pkg::K_SP;
                end else if (code == sbcc_pkg::CODE_PC) begin
                    n_kind = sbcc_pkg::K_PC;
                end else begin
                    n_kind = sbcc_pkg::K_OV;
                end
            end
            sbcc_pkg::S_NW: begin
                n_state = sbcc_pkg::S_RD;
                n_kind  = sbcc_pkg::K_MEM;
                if (code == sbcc_pkg::CODE_NWLIT) begin
                    n_kind  = sbcc_pkg::K_LIT;
                    n_where = mem_q;
                end else if (code == sbcc_pkg::CODE_NWIND) begin
                    n_where = mem_q;
                end else begin
                    n_where = rf_q + mem_q;
                end
            end
            sbcc_pkg::S_RD: begin
                fin = 1'b1;
                case (r_kind)
                    sbcc_pkg::K_REG: fin_val = rf_q;
                    sbcc_pkg::K_SP:  fin_val = r_sp;
                    sbcc_pkg::K_PC:  fin_val = r_pc;
                    sbcc_pkg::K_OV:  fin_val = r_ov;
                    sbcc_pkg::K_LIT: fin_val = r_where;
                    default: begin
                        fin          = 1'b0;
                        mem_req.en   = 1'b1;
                        mem_req.addr = r_where[AW-1:0];
                        n_state      = sbcc_pkg::S_RDW;
                    end
                endcase
            end
            sbcc_pkg::S_RDW: begin
                fin     = 1'b1;
                fin_val = mem_q;
            end
            sbcc_pkg::S_EXEC: begin
                n_state = sbcc_pkg::S_WB;
                if (op == sbcc_pkg::OP_DIV || op == sbcc_pkg::OP_MOD) begin
                    if (r_val_b == 16'h0000) begin
                        n_res = '0;
                        if (op == sbcc_pkg::OP_DIV) begin
                            n_ov = '0;
                        end
                    end else begin
                        div_start = 1'b1;
                        n_state   = sbcc_pkg::S_DIVW;
                    end
                end else if (op == sbcc_pkg::OP_IFE || op == sbcc_pkg::OP_IFN ||
                             op == sbcc_pkg::OP_IFG || op == sbcc_pkg::OP_IFB) begin
                    n_state = sbcc_pkg::S_DONE;
                    if (alu.cond) begin
                        mem_req.en   = 1'b1;
                        mem_req.addr = r_pc[AW-1:0];
                        n_pc         = r_pc + 16'd1;
                        n_state      = sbcc_pkg::S_SKW;
                    end
                end else begin
                    n_res = alu.res;
                    if (alu.ov_we) begin
                        n_ov = alu.ov;
                    end
                end
            end
            sbcc_pkg::S_DIVW: begin
                if (div_done) begin
                    n_state = sbcc_pkg::S_WB;
                    if (op == sbcc_pkg::OP_DIV) begin
                        n_res = div_quot[31:16];
                        n_ov  = div_quot[15:0];
                    end else begin
                        n_res = div_rem;
                    end
                end
            end
            // result goes back to operand a's place; literals swallow it
            sbcc_pkg::S_WB: begin
                n_state = sbcc_pkg::S_DONE;
                case (r_kind_a)
                    sbcc_pkg::K_REG: rf_we = 1'b1;
                    sbcc_pkg::K_MEM: begin
                        mem_req.en    = 1'b1;
                        mem_req.we    = 1'b1;
                        mem_req.addr  = r_where_a[AW-1:0];
                        mem_req.wdata = r_res;
                    end
                    sbcc_pkg::K_SP: n_sp = r_res;
                    sbcc_pkg::K_PC: n_pc = r_res;
                    sbcc_pkg::K_OV: n_ov = r_res;
                    default: ;
                endcase
            end
            // push return address, jump to operand
            sbcc_pkg::S_JSR: begin
                mem_req.en    = 1'b1;
                mem_req.we    = 1'b1;
                mem_req.addr  = r_sp[AW-1:0] - AW'(1);
                mem_req.wdata = r_pc;
                n_sp          = r_sp - 16'd1;
                n_pc          = r_val_a;
                n_state       = sbcc_pkg::S_DONE;
            end
            // skipped word: step past its operand words without evaluating them
            sbcc_pkg::S_SKW: begin
                if (mem_q[3:0] != 4'h0) begin
                    n_pc = r_pc + {15'h0, sbcc_pkg::takes_word(mem_q[9:4])}
                                + {15'h0, sbcc_pkg::takes_word(mem_q[15:10])};
                end else begin
                    n_pc = r_pc + {15'h0, sbcc_pkg::takes_word(mem_q[15:10])};
                end
                n_state = sbcc_pkg::S_DONE;
            end
            sbcc_pkg::S_DONE: n_state = sbcc_pkg::S_IDLE;
            default:          n_state = sbcc_pkg::S_IDLE;
        endcase

        // an operand value is settled: keep it and move on
        if (fin) begin
            if (!r_phb) begin
                n_kind_a  = r_kind;
                n_where_a = r_where;
                n_val_a   = fin_val;
                if (basic) begin
                    n_phb   = 1'b1;
                    n_state = sbcc_pkg::S_RES;
                end else if (r_ins[9:4] == sbcc_pkg::EXT_JSR) begin
                    n_state = sbcc_pkg::S_JSR;
                end else begin
                    n_unk   = 1'b1;
                    n_state = sbcc_pkg::S_DONE;
                end
            end else begin
                n_val_b = fin_val;
                n_state = sbcc_pkg::S_EXEC;
            end
        end
    end

    assign busy              = (r_state != sbcc_pkg::S_IDLE);
    assign o_valid           = (r_state == sbcc_pkg::S_DONE);
    assign o_read_data       = r_rdata;
    assign o_program_counter = r_pc;
    assign o_overflow_word   = r_ov;
    assign o_unknown_op      = r_unk;

    // an accepted word raises busy, and each strobe is single and followed by idle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted word did not raise busy");

    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> (!o_valid && !busy))
        else $error("result strobe not followed by idle");

    a_jsr_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == sbcc_pkg::S_JSR) |=> (r_sp == $past(r_sp) - 16'd1))
        else $error("jsr did not decrement stack pointer");

    a_unknown_only_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_unknown_op && o_valid) |-> (o_read_data == 16'h0000))
        else $error("unknown op flagged on a host read");
endmodule
`default_nettype wire

[verif/sixteen_bit_cpu_core_tb.sv]
// self-checking testbench for the sixteen-bit processor core: host accesses and executed instructions
`default_nettype none
module sixteen_bit_cpu_core_tb;
    import sbcc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int RANDOM_WORDS = 1600;
    localparam logic [15:0] ADDR_MASK = 16'(MEM_WORDS - 1);

    // one host word with the result it must produce
    typedef struct {
        t_cmd        cmd;
        logic [15:0] addr;
        logic [15:0] data;
        logic [15:0] rd;
        logic [15:0] pc;
        logic [15:0] ov;
        logic        unk;
    } t_word;

    typedef struct {
        t_kind       kind;
        logic [15:0] where;
        logic [15:0] lit;
    } t_place;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [1:0]  i_opcode = '0;
    logic [15:0] i_address = '0;
    logic [15:0] i_write_data = '0;
    logic        o_valid;
    logic [15:0] o_read_data;
    logic [15:0] o_program_counter;
    logic [15:0] o_overflow_word;
    logic        o_unknown_op;

    sixteen_bit_cpu_core dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_opcode(i_opcode), .i_address(i_address), .i_write_data(i_write_data),
        .o_valid(o_valid), .o_read_data(o_read_data),
        .o_program_counter(o_program_counter), .o_overflow_word(o_overflow_word),
        .o_unknown_op(o_unknown_op)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // shadow copy of the core state
    logic [15:0] shadow_mem [0:MEM_WORDS-1];
    bit          mem_known [0:MEM_WORDS-1];
    logic [15:0] known_addrs [$];
    logic [15:0] gpr [8];
    logic [15:0] pc_q, sp_q, ov_q;

    // a read of a never-written word during a trial run is noted here
    bit          hole_hit;
    logic [15:0] hole_addr;

    t_word pending_words [$];
    t_word awaited [$];
    int    errors = 0;
    bit    stim_done = 1'b0;

    function automatic logic [15:0] peek(input logic [15:0] a);
        logic [15:0] m;
        m = a & ADDR_MASK;
        if (!mem_known[m] && !hole_hit) begin
            hole_hit  = 1'b1;
            hole_addr = m;
        end
        return shadow_mem[m];
    endfunction

    function automatic void poke(input logic [15:0] a, input logic [15:0] v);
        logic [15:0] m;
        m = a & ADDR_MASK;
        if (hole_hit) return;
        shadow_mem[m] = v;
        if (!mem_known[m]) begin
            mem_known[m] = 1'b1;
            known_addrs.push_back(m);
        end
    endfunction

    function automatic logic [15:0] fetch_word();
        logic [15:0] w;
        w = peek(pc_q);
        pc_q = pc_q + 16'd1;
        return w;
    endfunction

    function automatic bit needs_word(input logic [5:0] c);
        return (c >= 6'h10 && c <= 6'h17) || c == CODE_NWIND || c == CODE_NWLIT;
    endfunction

    function automatic t_place locate(input logic [5:0] c);
        t_place p;
        p.kind  = K_MEM;
        p.where = '0;
        p.lit   = '0;
        if (c < 6'h08) begin
            p.kind  = K_REG;
            p.where = {13'd0, c[2:0]};
        end else if (c < 6'h10) begin
            p.where = gpr[c[2:0]];
        end else if (c < 6'h18) begin
            p.where = gpr[c[2:0]] + fetch_word();
        end else if (c == CODE_POP) begin
            p.where = sp_q;
            sp_q = sp_q + 16'd1;
        end else if (c == CODE_PEEK) begin
            p.where = sp_q;
        end else if (c == CODE_PUSH) begin
            sp_q = sp_q - 16'd1;
            p.where = sp_q;
        end else if (c == CODE_SP) begin
            p.kind = K_SP;
        end else if (c == CODE_PC) begin
            p.kind = K_PC;
        end else if (c == CODE_O) begin
            p.kind = K_OV;
        end else if (c == CODE_NWIND) begin
            p.where = fetch_word();
        end else if (c == CODE_NWLIT) begin
            p.kind = K_LIT;
            p.lit  = fetch_word();
        end else begin
            p.kind = K_LIT;
            p.lit  = {11'd0, c[4:0]};
        end
        return p;
    endfunction

    function automatic logic [15:0] fetch_place(input t_place p);
        case (p.kind)
            K_REG:   return gpr[p.where[2:0]];
            K_MEM:   return peek(p.where);
            K_SP:    return sp_q;
            K_PC:    return pc_q;
            K_OV:    return ov_q;
            default: return p.lit;
        endcase
    endfunction

    function automatic void store_place(input t_place p, input logic [15:0] v);
        if (hole_hit) return;
        case (p.kind)
            K_REG:   gpr[p.where[2:0]] = v;
            K_MEM:   poke(p.where, v);
            K_SP:    sp_q = v;
            K_PC:    pc_q = v;
            K_OV:    ov_q = v;
            default: ;
        endcase
    endfunction

    // skip over the next instruction and its operand words
    function automatic void skip_instr();
        logic [15:0] ins;
        ins = fetch_word();
        if (ins[3:0] != OP_EXT && needs_word(ins[9:4])) pc_q = pc_q + 16'd1;
        if (needs_word(ins[15:10])) pc_q = pc_q + 16'd1;
    endfunction

    // executes one instruction on the shadow state, returns the unknown-opcode flag
    function automatic logic step_instr();
        logic [15:0] ins;
        t_place      pa, pb;
        logic [31:0] a, b, res;
        logic [63:0] wide;
        ins = fetch_word();
        if (ins[3:0] == OP_EXT) begin
            pa = locate(ins[15:10]);
            a  = {16'd0, fetch_place(pa)};
            if (ins[9:4] != EXT_JSR) return 1'b1;
            if (hole_hit) return 1'b0;
            sp_q = sp_q - 16'd1;
            poke(sp_q, pc_q);
            pc_q = a[15:0];
            return 1'b0;
        end
        pa  = locate(ins[9:4]);
        a   = {16'd0, fetch_place(pa)};
        pb  = locate(ins[15:10]);
        b   = {16'd0, fetch_place(pb)};
        res = '0;
        if (hole_hit) return 1'b0;
        case (t_op'(ins[3:0]))
            OP_SET: res = b;
            OP_ADD: begin
                res  = a + b;
                ov_q = res[31:16];
            end
            OP_SUB: begin
                res  = a - b;
                ov_q = res[31:16];
            end
            OP_MUL: begin
                res  = a * b;
                ov_q = res[31:16];
            end
            OP_DIV: begin
                if (b != 0) begin
                    res  = a / b;
                    ov_q = 16'(((a << 16) / b));
                end else begin
                    ov_q = '0;
                end
            end
            OP_MOD: res = (b != 0) ? a % b : 32'd0;
            OP_SHL: begin
                wide = (b < 32) ? ({32'd0, a} << b) : 64'd0;
                res  = {16'd0, wide[15:0]};
                ov_q = wide[31:16];
            end
            OP_SHR: begin
                res  = (b < 32) ? (a >> b) : 32'd0;
                wide = (b < 48) ? (({32'd0, a} << 16) >> b) : 64'd0;
                ov_q = wide[15:0];
            end
            OP_AND: res = a & b;
            OP_BOR: res = a | b;
            OP_XOR: res = a ^ b;
            OP_IFE: begin
                if (a != b) skip_instr();
                return 1'b0;
            end
            OP_IFN: begin
                if (a == b) skip_instr();
                return 1'b0;
            end
            OP_IFG: begin
                if (a <= b) skip_instr();
                return 1'b0;
            end
            default: begin
                if ((a & b) == 0) skip_instr();
                return 1'b0;
            end
        endcase
        store_place(pa, res[15:0]);
        return 1'b0;
    endfunction

    function automatic void queue_word(input t_cmd c, input logic [15:0] a,
                                       input logic [15:0] d, input logic [15:0] rd,
                                       input logic u);
        t_word w;
        w.cmd  = c;
        w.addr = a;
        w.data = d;
        w.rd   = rd;
        w.pc   = pc_q;
        w.ov   = ov_q;
        w.unk  = u;
        pending_words.push_back(w);
    endfunction

    function automatic void host_write(input logic [15:0] a, input logic [15:0] d);
        hole_hit = 1'b0;
        poke(a, d);
        queue_word(CMD_WRITE, a, d, '0, 1'b0);
    endfunction

    function automatic void host_read(input logic [15:0] a);
        queue_word(CMD_READ, a, 16'($urandom), shadow_mem[a & ADDR_MASK], 1'b0);
    endfunction

    // trial-run the instruction at pc; any never-written word it would read is
    // filled by a host write first, so the core never sees undefined memory
    function automatic void run_instr();
        logic [15:0] s_gpr [8];
        logic [15:0] s_pc, s_sp, s_ov;
        logic        unk;
        for (int n = 0; n < 64; n++) begin
            s_gpr    = gpr;
            s_pc     = pc_q;
            s_sp     = sp_q;
            s_ov     = ov_q;
            hole_hit = 1'b0;
            unk      = step_instr();
            if (!hole_hit) begin
                queue_word(CMD_EXEC, 16'($urandom), 16'($urandom), '0, unk);
                return;
            end
            gpr  = s_gpr;
            pc_q = s_pc;
            sp_q = s_sp;
            ov_q = s_ov;
            host_write(hole_addr, 16'($urandom));
        end
    endfunction

    function automatic logic [5:0] rand_operand();
        case ($urandom_range(0, 9))
            0, 1, 2: return 6'($urandom_range(0, 7));
            3:       return 6'($urandom_range(8, 23));
            4, 5:    return 6'($urandom_range(24, 31));
            default: return 6'($urandom_range(32, 63));
        endcase
    endfunction

    function automatic logic [15:0] rand_extra();
        return $urandom_range(0, 1) ? 16'($urandom_range(0, 40)) : 16'($urandom);
    endfunction

    // lays a random instruction with its operand words down at pc
    function automatic void place_instr();
        logic [3:0] op;
        logic [5:0] sel;
        op  = 4'($urandom_range(0, 15));
        sel = rand_operand();
        if (op == OP_EXT)
            sel = $urandom_range(0, 1) ? EXT_JSR : 6'($urandom);
        host_write(pc_q, {rand_operand(), sel, op});
        host_write(pc_q + 16'd1, rand_extra());
        host_write(pc_q + 16'd2, rand_extra());
    endfunction

    function automatic logic [15:0] pick_known();
        return known_addrs[$urandom_range(0, known_addrs.size() - 1)];
    endfunction

    task automatic report(input string what, input logic [15:0] want,
                          input logic [15:0] got);
        $display("mismatch on %s: expected %h, got %h at %0t", what, want, got, $realtime);
        errors++;
    endtask

    // stimulus: a short directed program, then random words
    initial begin
        for (int n = 0; n < 8; n++) gpr[n] = '0;
        pc_q = '0;
        sp_q = '0;
        ov_q = '0;

        // set a to all ones via next-word literal, then add and subtract carries
        host_write(16'd0, {CODE_NWLIT, 6'h00, 4'(OP_SET)});
        host_write(16'd1, 16'hffff);
        host_write(16'd2, {6'h21, 6'h00, 4'(OP_ADD)});
        host_write(16'd3, {6'h21, 6'h01, 4'(OP_SUB)});
        // multiply all ones by itself, divide by zero, shift by a huge count
        host_write(16'd4, {6'h01, 6'h01, 4'(OP_MUL)});
        host_write(16'd5, {6'h20, 6'h01, 4'(OP_DIV)});
        host_write(16'd6, {CODE_NWLIT, 6'h01, 4'(OP_SHL)});
        host_write(16'd7, 16'd40);
        // write to a literal is dropped; equal test lets a two-word push through
        host_write(16'd8, {6'h00, 6'h21, 4'(OP_SET)});
        host_write(16'd9, {6'h00, 6'h00, 4'(OP_IFE)});
        host_write(16'd10, {CODE_NWLIT, CODE_PUSH, 4'(OP_SET)});
        // subroutine call to 20 pushes the return address just below the top of memory
        host_write(16'd12, {CODE_NWLIT, EXT_JSR, 4'(OP_EXT)});
        host_write(16'd13, 16'd20);
        // undefined extended opcode still pops; then jump back to zero
        host_write(16'd20, {CODE_POP, 6'h3f, 4'(OP_EXT)});
        host_write(16'd21, {6'h20, CODE_PC, 4'(OP_SET)});
        repeat (11) run_instr();
        host_read(16'hffff);
        queue_word(CMD_NONE, 16'hffff, 16'hffff, '0, 1'b0);

        while (pending_words.size() < RANDOM_WORDS + 40) begin
            case ($urandom_range(0, 19))
                0, 1, 2: host_write(16'($urandom), 16'($urandom));
                3:       host_write(sp_q - 16'($urandom_range(0, 3)), rand_extra());
                4, 5:    host_read(pick_known());
                6:       queue_word(CMD_NONE, 16'($urandom), 16'($urandom), '0, 1'b0);
                7, 8, 9: run_instr();
                default: begin
                    place_instr();
                    run_instr();
                end
            endcase
        end
        stim_done = 1'b1;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // driver: presents pending words with random gaps, a word leaves on start && !busy
    int    gap_left = 0;
    int    calm_left = 0;
    t_word on_port;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) awaited.push_back(on_port);
            if (!start || !busy) begin
                if (gap_left > 0) begin
                    gap_left--;
                    start <= 1'b0;
                end else if (pending_words.size() > 0) begin
                    on_port      = pending_words.pop_front();
                    start        <= 1'b1;
                    i_opcode     <= on_port.cmd;
                    i_address    <= on_port.addr;
                    i_write_data <= on_port.data;
                    // alternate stretches with no gaps and stretches with gaps
                    if (calm_left > 0) begin
                        calm_left--;
                    end else if ($urandom_range(0, 49) == 0) begin
                        calm_left = $urandom_range(20, 80);
                    end else begin
                        case ($urandom_range(0, 9))
                            0, 1, 2, 3: gap_left = 0;
                            9:          gap_left = $urandom_range(10, 40);
                            default:    gap_left = $urandom_range(1, 3);
                        endcase
                    end
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // monitor: every strobed word is checked against the oldest expectation
    always @(posedge i_clk) begin
        t_word want;
        if (i_rst_n && o_valid) begin
            if (awaited.size() == 0) begin
                $display("result word with nothing expected at %0t", $realtime);
                errors++;
            end else begin
                want = awaited.pop_front();
                if (o_read_data !== want.rd) report("read_data", want.rd, o_read_data);
                if (o_program_counter !== want.pc)
                    report("program_counter", want.pc, o_program_counter);
                if (o_overflow_word !== want.ov)
                    report("overflow_word", want.ov, o_overflow_word);
                if (o_unknown_op !== want.unk)
                    report("unknown_op", 16'(want.unk), 16'(o_unknown_op));
            end
        end
    end

    // watchdog on the whole run
    int cycles = 0;
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // drain and close
    initial begin
        wait (stim_done && i_rst_n);
        @(posedge i_clk);
        while (pending_words.size() > 0 || start || awaited.size() > 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        if (errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
`default_nettype wire

[sim.f]
src/sbcc_pkg.sv
src/sbcc_mem.sv
src/sbcc_div.sv
src/sbcc_alu.sv
src/sixteen_bit_cpu_core.sv
verif/sixteen_bit_cpu_core_tb.sv
